/* rtl/tgbu_pkg.sv */
`timescale 1ns / 1ps

package tgbu_pkg;

   // Grid and field geometry
   localparam int GRID_SIDE    = 8;
   localparam int GRID_CELLS   = GRID_SIDE * GRID_SIDE;
   localparam int AXIS_W       = $clog2(GRID_SIDE);
   localparam int CELL_W       = $clog2(GRID_CELLS);
   localparam int SAMPLE_W     = 12;
   localparam int COORD_W      = 7;
   localparam int SIZE_W       = 8;
   localparam int FRAC_W       = 4;
   localparam int WEIGHT_W     = 2 * FRAC_W + 1;
   localparam int ACC_W        = SAMPLE_W + WEIGHT_W;
   localparam int NUM_W        = 14;
   localparam int QUO_W        = COORD_W;
   localparam int CSR_IDX_W    = 2;

   // Full weight of one axis: the number of fraction steps
   localparam logic [FRAC_W:0] FRAC_ONE = 5'd16;

   // Restoring divide: one quotient bit per step
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DIV_STEPS - 1);

   // Commands and status codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_PIXEL  = 1'b1;
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT = 2'd1;
   localparam logic [SIZE_W-1:0]    SIZE_RESET     = 8'd32;
   localparam logic [SIZE_W-1:0]    SIZE_MIN       = 8'd2;

   // Microcode
   localparam int UPC_W = 3;
   localparam logic [UPC_W-1:0] UPC_DIVIDE = 3'd0;
   localparam logic [UPC_W-1:0] UPC_LAST   = 3'd6;

   typedef enum logic {
      JMP_NEXT = 1'b0,
      JMP_LOOP = 1'b1
   } jmp_type;

   typedef struct packed {
      logic             div_step;
      logic             wgt;
      logic             mac;
      logic             done;
      logic [1:0]       term;
      jmp_type          jmp;
      logic [UPC_W-1:0] target;
   } ucw_type;

   localparam ucw_type UCW_NOP = '{
      div_step: 1'b0, wgt: 1'b0, mac: 1'b0, done: 1'b0,
      term: 2'd0, jmp: JMP_NEXT, target: UPC_DIVIDE
   };

   // Program: divide both axes, then four weight/read and multiply-add steps
   function automatic ucw_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucw_type cw;
      cw = UCW_NOP;
      case (addr)
         UPC_DIVIDE: begin
            cw.div_step = 1'b1;
            cw.jmp      = JMP_LOOP;
            cw.target   = UPC_DIVIDE;
         end
         3'd1: begin
            cw.wgt  = 1'b1;
            cw.term = 2'd0;
         end
         3'd2: begin
            cw.mac  = 1'b1;
            cw.wgt  = 1'b1;
            cw.term = 2'd1;
         end
         3'd3: begin
            cw.mac  = 1'b1;
            cw.wgt  = 1'b1;
            cw.term = 2'd2;
         end
         3'd4: begin
            cw.mac  = 1'b1;
            cw.wgt  = 1'b1;
            cw.term = 2'd3;
         end
         3'd5: begin
            cw.mac = 1'b1;
         end
         UPC_LAST: begin
            cw.done = 1'b1;
         end
         default: begin
            cw = UCW_NOP;
         end
      endcase
      return cw;
   endfunction

endpackage

/* rtl/thermal_grid_bilinear_upscale.sv */
`timescale 1ns / 1ps
// Pixel item: busy holds from the accept edge until rsp_strobe rises, through 7 shared
// divide steps (one quotient bit each), then the weight/read and multiply-add steps and
// a done step, so the next item is accepted only once busy drops with the result strobe.
// Load items and out-of-range pixels: busy stays low, one item per cycle; an error
// result strobes in the cycle after acceptance. The receiver cannot stall results.
// Reset (synchronous): sizes return to 32 by 32, sequencer idle; grid holds no reset.
module thermal_grid_bilinear_upscale (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_cmd,
   input  logic [tgbu_pkg::CELL_W-1:0]          req_cell_index,
   input  logic signed [tgbu_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [tgbu_pkg::COORD_W-1:0]         req_pixel_x,
   input  logic [tgbu_pkg::COORD_W-1:0]         req_pixel_y,
   output logic                                 rsp_strobe,
   output logic signed [tgbu_pkg::SAMPLE_W-1:0] rsp_temperature_quarters,
   output logic                                 rsp_status,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tgbu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tgbu_pkg::SIZE_W-1:0]          csr_data
);

   logic                                 accept, pixel, range_err, go, load_en;
   logic [tgbu_pkg::SIZE_W-1:0]          width_ff, height_ff;
   logic                                 strobe_ff, strobe_in;
   logic                                 status_ff, status_in;
   logic signed [tgbu_pkg::SAMPLE_W-1:0] temp_ff, temp_in, dp_result;
   tgbu_pkg::ucw_type                    ctrl;

   // Decode the accepted item
   always_comb begin
      accept    = start && !busy;
      pixel     = req_cmd == tgbu_pkg::CMD_PIXEL;
      range_err = width_ff < tgbu_pkg::SIZE_MIN || height_ff < tgbu_pkg::SIZE_MIN
                  || {1'b0, req_pixel_x} >= width_ff || {1'b0, req_pixel_y} >= height_ff;
      go        = accept && pixel && !range_err;
      load_en   = accept && req_cmd == tgbu_pkg::CMD_LOAD;
   end

   // Hold the size registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tgbu_pkg::SIZE_RESET;
         height_ff <= tgbu_pkg::SIZE_RESET;
      end else if (csr_valid) begin
         if (csr_index == tgbu_pkg::CSR_OUT_WIDTH) begin
            width_ff <= csr_data;
         end else if (csr_index == tgbu_pkg::CSR_OUT_HEIGHT) begin
            height_ff <= csr_data;
         end
      end
   end

   tgbu_useq u_useq (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   tgbu_datapath u_datapath (
      .clock      (clock),
      .ctrl       (ctrl),
      .go         (go),
      .pixel_x    (req_pixel_x),
      .pixel_y    (req_pixel_y),
      .out_width  (width_ff),
      .out_height (height_ff),
      .load_en    (load_en),
      .cell_index (req_cell_index),
      .sample     (req_sample),
      .result     (dp_result)
   );

   // Register the result: error at accept, value at program end
   always_comb begin
      strobe_in = 1'b0;
      status_in = tgbu_pkg::STATUS_OK;
      temp_in   = temp_ff;
      if (accept && pixel && range_err) begin
         strobe_in = 1'b1;
         status_in = tgbu_pkg::STATUS_ERR;
         temp_in   = '0;
      end else if (ctrl.done) begin
         strobe_in = 1'b1;
         temp_in   = dp_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      status_ff <= status_in;
      temp_ff   <= temp_in;
   end

   assign rsp_strobe               = strobe_ff;
   assign rsp_status               = status_ff;
   assign rsp_temperature_quarters = temp_ff;

endmodule

/* rtl/tgbu_useq.sv */
`timescale 1ns / 1ps

module tgbu_useq (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   output logic              busy,
   output tgbu_pkg::ucw_type ctrl
);

   logic                              busy_ff, busy_in;
   logic [tgbu_pkg::UPC_W-1:0]        upc_ff, upc_in;
   logic [tgbu_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   tgbu_pkg::ucw_type                 cw;

   // Fetch the control word of the current step
   always_comb begin
      cw   = tgbu_pkg::ucode_rom(upc_ff);
      ctrl = busy_ff ? cw : tgbu_pkg::UCW_NOP;
   end

   // Advance the step counter, loop while iterations remain
   always_comb begin
      busy_in = busy_ff;
      upc_in  = upc_ff;
      cnt_in  = cnt_ff;
      if (!busy_ff) begin
         if (go) begin
            busy_in = 1'b1;
            upc_in  = tgbu_pkg::UPC_DIVIDE;
            cnt_in  = tgbu_pkg::CNT_LOAD;
         end
      end else begin
         if (cw.div_step) begin
            cnt_in = cnt_ff - 1'b1;
         end
         if (cw.done) begin
            busy_in = 1'b0;
         end else if (cw.jmp == tgbu_pkg::JMP_LOOP && cnt_ff != '0) begin
            upc_in = cw.target;
         end else begin
            upc_in = upc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= tgbu_pkg::UPC_DIVIDE;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign busy = busy_ff;

endmodule

/* rtl/tgbu_datapath.sv */
`timescale 1ns / 1ps

module tgbu_datapath (
   input  logic                                 clock,
   input  tgbu_pkg::ucw_type                    ctrl,
   input  logic                                 go,
   input  logic [tgbu_pkg::COORD_W-1:0]         pixel_x,
   input  logic [tgbu_pkg::COORD_W-1:0]         pixel_y,
   input  logic [tgbu_pkg::SIZE_W-1:0]          out_width,
   input  logic [tgbu_pkg::SIZE_W-1:0]          out_height,
   input  logic                                 load_en,
   input  logic [tgbu_pkg::CELL_W-1:0]          cell_index,
   input  logic signed [tgbu_pkg::SAMPLE_W-1:0] sample,
   output logic signed [tgbu_pkg::SAMPLE_W-1:0] result
);

   localparam int SW = tgbu_pkg::SIZE_W;
   localparam int QW = tgbu_pkg::QUO_W;
   localparam int NW = tgbu_pkg::NUM_W;
   localparam int AW = tgbu_pkg::AXIS_W;
   localparam int FW = tgbu_pkg::FRAC_W;
   localparam int WW = tgbu_pkg::WEIGHT_W;
   localparam int XW = tgbu_pkg::ACC_W;
   localparam int DW = tgbu_pkg::SAMPLE_W;

   // Divider lanes for x and y
   logic [SW-1:0] div_x_ff, div_y_ff;
   logic [SW-1:0] rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [QW-1:0] quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic [NW-1:0] num_x, num_y;
   logic [SW:0]   try_x, try_y, dif_x, dif_y;
   logic          ge_x, ge_y;

   // Weight, read and accumulate
   logic [AW-1:0]               gx, gy, ax, ay;
   logic [FW-1:0]               fx, fy;
   logic [FW:0]                 wx, wy;
   logic [2*FW+1:0]             wprod;
   logic [WW-1:0]               weight_ff;
   logic [tgbu_pkg::CELL_W-1:0] rd_addr;
   logic signed [DW-1:0]        rd_data_ff;
   logic signed [DW-1:0]        grid_mem [tgbu_pkg::GRID_CELLS];
   logic signed [DW+WW:0]       product;
   logic signed [XW-1:0]        acc_ff, acc_in, acc_adj;

   // Scale coordinates by 112 with shifts
   assign num_x = {pixel_x, 7'd0} - {3'd0, pixel_x, 4'd0};
   assign num_y = {pixel_y, 7'd0} - {3'd0, pixel_y, 4'd0};

   // One restoring step per lane
   always_comb begin
      try_x    = {rem_x_ff, quo_x_ff[QW-1]};
      try_y    = {rem_y_ff, quo_y_ff[QW-1]};
      dif_x    = try_x - {1'b0, div_x_ff};
      dif_y    = try_y - {1'b0, div_y_ff};
      ge_x     = try_x >= {1'b0, div_x_ff};
      ge_y     = try_y >= {1'b0, div_y_ff};
      rem_x_in = ge_x ? dif_x[SW-1:0] : try_x[SW-1:0];
      rem_y_in = ge_y ? dif_y[SW-1:0] : try_y[SW-1:0];
      quo_x_in = {quo_x_ff[QW-2:0], ge_x};
      quo_y_in = {quo_y_ff[QW-2:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (go) begin
         div_x_ff <= out_width - 1'b1;
         div_y_ff <= out_height - 1'b1;
         rem_x_ff <= {1'b0, num_x[NW-1:QW]};
         rem_y_ff <= {1'b0, num_y[NW-1:QW]};
         quo_x_ff <= num_x[QW-1:0];
         quo_y_ff <= num_y[QW-1:0];
      end else if (ctrl.div_step) begin
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         quo_x_ff <= quo_x_in;
         quo_y_ff <= quo_y_in;
      end
   end

   // Pick the cell and weight of the current corner
   always_comb begin
      gx      = quo_x_ff[QW-1:FW];
      gy      = quo_y_ff[QW-1:FW];
      fx      = quo_x_ff[FW-1:0];
      fy      = quo_y_ff[FW-1:0];
      wx      = ctrl.term[0] ? {1'b0, fx} : tgbu_pkg::FRAC_ONE - {1'b0, fx};
      wy      = ctrl.term[1] ? {1'b0, fy} : tgbu_pkg::FRAC_ONE - {1'b0, fy};
      wprod   = wx * wy;
      ax      = gx + {{(AW-1){1'b0}}, ctrl.term[0]};
      ay      = gy + {{(AW-1){1'b0}}, ctrl.term[1]};
      rd_addr = {ay, ax};
   end

   // Store loads, read one cell per step
   always_ff @(posedge clock) begin
      if (load_en) begin
         grid_mem[cell_index] <= sample;
      end
      if (ctrl.wgt) begin
         rd_data_ff <= grid_mem[rd_addr];
         weight_ff  <= wprod[WW-1:0];
      end
   end

   // Multiply-add, drop corners that carry no weight
   always_comb begin
      product = rd_data_ff * $signed({1'b0, weight_ff});
      acc_in  = acc_ff;
      if (go) begin
         acc_in = '0;
      end else if (ctrl.mac && weight_ff != '0) begin
         acc_in = acc_ff + product[XW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Divide by 256 toward zero and keep the low 12 bits
   always_comb begin
      acc_adj = acc_ff + (acc_ff[XW-1] ? XW'(255) : XW'(0));
      result  = acc_adj[DW+7:8];
   end

endmodule

/* tb/thermal_grid_bilinear_upscale_tb.sv */
`timescale 1ns / 1ps

module thermal_grid_bilinear_upscale_tb;

   import tgbu_pkg::*;

   localparam int FRAC_STEPS     = 16;
   localparam int GRID_SPAN      = GRID_SIDE - 1;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTINGS_PER_PHASE = 6;
   localparam int ITEMS_PER_SETTING  = 98;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP      = 2'd3;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = SAMPLE_W'(-2048);
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(2047);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] temp;
      logic                       status;
   } pixel_reading_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic                        req_cmd;
   logic [CELL_W-1:0]           req_cell_index;
   logic signed [SAMPLE_W-1:0]  req_sample;
   logic [COORD_W-1:0]          req_pixel_x;
   logic [COORD_W-1:0]          req_pixel_y;
   logic                        rsp_strobe;
   logic signed [SAMPLE_W-1:0]  rsp_temperature_quarters;
   logic                        rsp_status;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [SIZE_W-1:0]           csr_data;

   // Shadow state of the block
   logic signed [SAMPLE_W-1:0]  grid_copy [GRID_CELLS];
   logic [SIZE_W-1:0]           cfg_width;
   logic [SIZE_W-1:0]           cfg_height;

   pixel_reading_type pending_readings [$];
   pixel_reading_type expected_reading;
   int                failures;
   int                idle_pct;
   int                quiet_cycles;

   thermal_grid_bilinear_upscale i_dut (
      .clock                    (clock),
      .reset                    (reset),
      .start                    (start),
      .busy                     (busy),
      .req_cmd                  (req_cmd),
      .req_cell_index           (req_cell_index),
      .req_sample               (req_sample),
      .req_pixel_x              (req_pixel_x),
      .req_pixel_y              (req_pixel_y),
      .rsp_strobe               (rsp_strobe),
      .rsp_temperature_quarters (rsp_temperature_quarters),
      .rsp_status               (rsp_status),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Bilinear value of one output pixel from the shadow grid and sizes
   function automatic pixel_reading_type interpolate_pixel(input logic [COORD_W-1:0] px,
                                                           input logic [COORD_W-1:0] py);
      pixel_reading_type r;
      int xi, yi, wi, hi, sx, sy, gx, gy, fx0, fx1, fy0, fy1, base, acc;
      r.temp   = '0;
      r.status = STATUS_ERR;
      xi = int'(px);
      yi = int'(py);
      wi = int'(cfg_width);
      hi = int'(cfg_height);
      if (wi < 2 || hi < 2 || xi >= wi || yi >= hi) begin
         return r;
      end
      sx   = FRAC_STEPS * xi * GRID_SPAN / (wi - 1);
      sy   = FRAC_STEPS * yi * GRID_SPAN / (hi - 1);
      gx   = sx / FRAC_STEPS;
      gy   = sy / FRAC_STEPS;
      fx1  = sx % FRAC_STEPS;
      fy1  = sy % FRAC_STEPS;
      fx0  = FRAC_STEPS - fx1;
      fy0  = FRAC_STEPS - fy1;
      base = gx + gy * GRID_SIDE;
      if (xi == wi - 1 && yi == hi - 1) begin
         acc = grid_copy[base];
      end else if (xi == wi - 1) begin
         acc = (grid_copy[base] * fy0 + grid_copy[base + GRID_SIDE] * fy1) / FRAC_STEPS;
      end else if (yi == hi - 1) begin
         acc = (grid_copy[base] * fx0 + grid_copy[base + 1] * fx1) / FRAC_STEPS;
      end else begin
         acc = (grid_copy[base] * fx0 * fy0
              + grid_copy[base + 1] * fx1 * fy0
              + grid_copy[base + GRID_SIDE] * fx0 * fy1
              + grid_copy[base + GRID_SIDE + 1] * fx1 * fy1) / (FRAC_STEPS * FRAC_STEPS);
      end
      r.temp   = acc[SAMPLE_W-1:0];
      r.status = STATUS_OK;
      return r;
   endfunction

   // Drive one item, hold it until accepted, then record its effect
   task automatic send_item(input logic cmd, input logic [CELL_W-1:0] cell_idx,
                            input logic signed [SAMPLE_W-1:0] sample,
                            input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_cell_index <= cell_idx;
      req_sample     <= sample;
      req_pixel_x    <= px;
      req_pixel_y    <= py;
      do @(posedge clock); while (busy);
      if (cmd == CMD_LOAD) begin
         grid_copy[cell_idx] = sample;
      end else begin
         pending_readings.push_back(interpolate_pixel(px, py));
      end
   endtask

   // Load a cell; pixel fields carry noise
   task automatic send_load(input logic [CELL_W-1:0] cell_idx,
                            input logic signed [SAMPLE_W-1:0] sample);
      send_item(CMD_LOAD, cell_idx, sample, COORD_W'($urandom_range(0, 127)),
                COORD_W'($urandom_range(0, 127)));
   endtask

   // Ask for a pixel; load fields carry noise
   task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
      send_item(CMD_PIXEL, CELL_W'($urandom_range(0, GRID_CELLS - 1)),
                SAMPLE_W'($urandom_range(0, 4095)), px, py);
   endtask

   // Hold off the sender until every reading is back and the block is quiet
   task automatic drain_pipeline();
      start <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_OUT_WIDTH) begin
         cfg_width = value;
      end else if (idx == CSR_OUT_HEIGHT) begin
         cfg_height = value;
      end
   endtask

   task automatic set_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      write_csr(CSR_OUT_WIDTH, w);
      write_csr(CSR_OUT_HEIGHT, h);
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 19))
         0:       return SIZE_W'($urandom_range(0, 1));
         1, 2:    return 8'd2;
         3:       return 8'd3;
         4, 5:    return 8'd128;
         6:       return SIZE_W'($urandom_range(129, 255));
         default: return SIZE_W'($urandom_range(2, 128));
      endcase
   endfunction

   // Random pixel, inside the image or pushed outside it on one axis
   task automatic send_random_pixel(input bit in_range);
      int xmax, ymax;
      logic [COORD_W-1:0] px, py;
      xmax = (cfg_width == 0 || cfg_width > 128) ? 127 : int'(cfg_width) - 1;
      ymax = (cfg_height == 0 || cfg_height > 128) ? 127 : int'(cfg_height) - 1;
      px = COORD_W'($urandom_range(0, xmax));
      py = COORD_W'($urandom_range(0, ymax));
      // Favor the last row and column
      if ($urandom_range(0, 7) == 0) px = COORD_W'(xmax);
      if ($urandom_range(0, 7) == 0) py = COORD_W'(ymax);
      if (!in_range) begin
         if (cfg_width < 128 && ($urandom_range(0, 1) == 1 || cfg_height >= 128)) begin
            px = COORD_W'($urandom_range(int'(cfg_width), 127));
         end else if (cfg_height < 128) begin
            py = COORD_W'($urandom_range(int'(cfg_height), 127));
         end
      end
      send_pixel(px, py);
   endtask

   // Fill every cell so that no pixel reads an unwritten one
   task automatic test_grid_fill();
      for (int i = 0; i < GRID_CELLS; i++) begin
         case (i)
            0:       send_load(CELL_W'(i), SAMPLE_MIN);
            1:       send_load(CELL_W'(i), SAMPLE_MAX);
            8:       send_load(CELL_W'(i), -12'sd1);
            9:       send_load(CELL_W'(i), 12'sd0);
            default: send_load(CELL_W'(i), SAMPLE_W'($urandom_range(0, 4095)));
         endcase
      end
   endtask

   // Corners, edges, interior and out-of-range pixels at the reset size
   task automatic test_reset_size();
      send_pixel(0, 0);
      send_pixel(31, 0);
      send_pixel(0, 31);
      send_pixel(31, 31);
      send_pixel(16, 9);
      send_pixel(1, 1);
      send_pixel(32, 0);
      send_pixel(0, 32);
      send_pixel(127, 127);
   endtask

   // Overwrite cells with the sample extremes and read them back through corners
   task automatic test_load_overwrite();
      send_load(63, SAMPLE_MIN);
      send_load(0, SAMPLE_MAX);
      send_pixel(31, 31);
      send_pixel(0, 0);
   endtask

   // Smallest, largest and degenerate sizes, and writes to both unmapped registers
   task automatic test_size_extremes();
      set_size(8'd2, 8'd2);
      send_pixel(0, 0);
      send_pixel(1, 0);
      send_pixel(0, 1);
      send_pixel(1, 1);
      send_pixel(2, 0);
      set_size(8'd128, 8'd128);
      send_pixel(127, 0);
      send_pixel(127, 127);
      send_pixel(64, 100);
      set_size(8'd255, 8'd3);
      send_pixel(127, 2);
      send_pixel(5, 1);
      set_size(8'd1, 8'd32);
      send_pixel(0, 0);
      set_size(8'd32, 8'd0);
      send_pixel(0, 0);
      write_csr(CSR_UNMAPPED, 8'd5);
      write_csr(CSR_TOP, 8'd7);
      set_size(8'd32, 8'd32);
      send_pixel(31, 31);
   endtask

   // Random mix of pixels, off-image pixels and loads over several sizes
   task automatic test_random(input int sender_idle_pct);
      int pick;
      idle_pct = sender_idle_pct;
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
         set_size(pick_size(), pick_size());
         for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               send_random_pixel(1'b1);
            end else if (pick < 82) begin
               send_random_pixel(1'b0);
            end else if (pick < 86) begin
               send_load(CELL_W'($urandom_range(0, GRID_CELLS - 1)),
                         $urandom_range(0, 1) ? SAMPLE_MIN : SAMPLE_MAX);
            end else begin
               send_load(CELL_W'($urandom_range(0, GRID_CELLS - 1)),
                         SAMPLE_W'($urandom_range(0, 4095)));
            end
            // Pause now and then until all readings are back
            if ($urandom_range(0, 199) == 0) drain_pipeline();
         end
      end
   endtask

   // Compare each reading with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_readings.size() == 0) begin
            $error("unexpected reading: temperature_quarters %0d status %0d",
                   rsp_temperature_quarters, rsp_status);
            failures++;
         end else begin
            expected_reading = pending_readings.pop_front();
            if (rsp_temperature_quarters !== expected_reading.temp) begin
               $error("temperature_quarters: expected %0d, got %0d",
                      expected_reading.temp, rsp_temperature_quarters);
               failures++;
            end
            if (rsp_status !== expected_reading.status) begin
               $error("status: expected %0d, got %0d", expected_reading.status, rsp_status);
               failures++;
            end
         end
      end
   end

   // Stop a run that makes no progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_cmd        = CMD_LOAD;
      req_cell_index = '0;
      req_sample     = '0;
      req_pixel_x    = '0;
      req_pixel_y    = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_OUT_WIDTH;
      csr_data       = '0;
      cfg_width      = SIZE_RESET;
      cfg_height     = SIZE_RESET;
      failures       = 0;
      idle_pct       = 0;
      quiet_cycles   = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_grid_fill();
      test_reset_size();
      test_load_overwrite();
      test_size_extremes();
      test_random(24);
      test_random(60);
      test_random(0);

      drain_pipeline();
      if (pending_readings.size() != 0) begin
         $error("%0d readings never arrived", pending_readings.size());
         failures++;
      end
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
